// ----- design/rttc_pkg.sv -----
// Shared types, constants and a helper function of the transmit timeout calculator.
package rttc_pkg;

   // One divider cell resolves one quotient bit.
   localparam int NUM_CELLS = 20;
   // Three front stages, the divider chain and four back stages.
   localparam int NUM_STAGES = NUM_CELLS + 7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODULATION = 2'd0;
   localparam logic [1:0] CSR_SPREADING = 2'd1;
   localparam logic [1:0] CSR_BANDWIDTH = 2'd2;
   localparam logic [1:0] CSR_BITRATE = 2'd3;

   // Modulation codes.
   localparam logic MOD_LORA = 1'b0;
   localparam logic MOD_FLRC = 1'b1;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic [21:0] rem;
      logic [19:0] num;
      logic [19:0] quot;
      logic [21:0] divisor;
      logic        modulation;
      logic [11:0] qsym;
   } div_type;

   // Reciprocal ceil(2^18 / (4 * (sf - 2))) for the low-data-rate block count.
   function automatic logic [14:0] ldr_recip(input logic [3:0] sf);
      logic [14:0] r;
      case (sf)
         4'd5: r = 15'd21846;
         4'd6: r = 15'd16384;
         4'd7: r = 15'd13108;
         4'd8: r = 15'd10923;
         4'd9: r = 15'd9363;
         4'd10: r = 15'd8192;
         4'd11: r = 15'd7282;
         default: r = 15'd6554;
      endcase
      return r;
   endfunction

endpackage

// ----- design/rttc_div_cell.sv -----
// One restoring divider cell: resolves one quotient bit per transaction.
module rttc_div_cell (
   input  logic             clock,
   input  logic             en,
   input  rttc_pkg::div_type cell_i,
   output rttc_pkg::div_type cell_o
);
   import rttc_pkg::*;

   logic [22:0] trial;
   logic        fits;
   div_type     cell_in;
   div_type     cell_ff;

   // Shift in the next numerator bit and subtract the divisor when it fits.
   always_comb begin
      trial = {cell_i.rem, cell_i.num[19]};
      fits = trial >= {1'b0, cell_i.divisor};
      cell_in = cell_i;
      cell_in.rem = fits ? 22'(trial - {1'b0, cell_i.divisor}) : trial[21:0];
      cell_in.num = {cell_i.num[18:0], 1'b0};
      cell_in.quot = {cell_i.quot[18:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;
endmodule

// ----- design/rttc_prep.sv -----
// Front stages: clamp settings, count symbols or coded bits, build the dividend.
module rttc_prep (
   input  logic              clock,
   input  logic [2:0]        en,
   input  logic [7:0]        payload_length,
   input  logic              modulation,
   input  logic [3:0]        spreading_factor,
   input  logic [19:0]       lora_bandwidth_hz,
   input  logic [21:0]       flrc_bitrate_bps,
   output rttc_pkg::div_type cell_o
);
   import rttc_pkg::*;

   logic [7:0]  len_a_ff;
   logic        mod_a_ff;
   logic [3:0]  sf_a_ff;
   logic [21:0] div_a_ff;
   logic [3:0]  sf_in;
   logic [21:0] div_in;

   logic [13:0] pos_bits;
   logic        has_bits;
   logic [11:0] bits_b;
   logic [5:0]  ldr_div;
   logic [11:0] bits_round;
   logic [26:0] blocks_prod;
   logic [8:0]  blocks_in;
   logic [13:0] flrc_round;
   logic [30:0] coded_prod;
   logic [11:0] coded_in;

   logic        mod_b_ff;
   logic [3:0]  sf_b_ff;
   logic [21:0] div_b_ff;
   logic [8:0]  blocks_b_ff;
   logic [11:0] coded_b_ff;

   logic [31:0] numer;
   div_type     cell_in;
   div_type     cell_ff;

   // Clamp the settings and pick the divisor of the active modulation.
   always_comb begin
      sf_in = spreading_factor;
      if (spreading_factor < 4'd5) begin
         sf_in = 4'd5;
      end else if (spreading_factor > 4'd12) begin
         sf_in = 4'd12;
      end
      if (modulation == MOD_FLRC) begin
         div_in = (flrc_bitrate_bps < 22'd260000) ? 22'd260000 : flrc_bitrate_bps;
      end else begin
         div_in = (lora_bandwidth_hz < 20'd7800) ? 22'd7800 : {2'b00, lora_bandwidth_hz};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         len_a_ff <= payload_length;
         mod_a_ff <= modulation;
         sf_a_ff <= sf_in;
         div_a_ff <= div_in;
      end
   end

   // LoRa block count with the smaller divisor, and FLRC coded bit count.
   always_comb begin
      pos_bits = {3'b000, len_a_ff, 3'b000} + 14'd44;
      has_bits = pos_bits > {8'd0, sf_a_ff, 2'b00};
      bits_b = 12'(pos_bits - {8'd0, sf_a_ff, 2'b00});
      ldr_div = {4'(sf_a_ff - 4'd2), 2'b00};
      bits_round = 12'(bits_b + {6'd0, ldr_div} - 12'd1);
      blocks_prod = bits_round * ldr_recip(sf_a_ff);
      blocks_in = has_bits ? blocks_prod[26:18] : 9'd0;
      flrc_round = {1'b0, len_a_ff, 5'b00000} + 14'd322;
      coded_prod = flrc_round * 17'd43691;
      coded_in = coded_prod[28:17];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mod_b_ff <= mod_a_ff;
         sf_b_ff <= sf_a_ff;
         div_b_ff <= div_a_ff;
         blocks_b_ff <= blocks_in;
         coded_b_ff <= coded_in;
      end
   end

   // Dividend with round-up term; the quarter-symbol count rides along.
   always_comb begin
      if (mod_b_ff == MOD_FLRC) begin
         numer = 32'(coded_b_ff) * 32'd1000000 + {10'd0, div_b_ff} - 32'd1;
      end else begin
         numer = (32'd1000000 << sf_b_ff) + {10'd0, div_b_ff} - 32'd1;
      end
      cell_in.rem = {10'd0, numer[31:20]};
      cell_in.num = numer[19:0];
      cell_in.quot = '0;
      cell_in.divisor = div_b_ff;
      cell_in.modulation = mod_b_ff;
      cell_in.qsym = 12'd81 + {3'd0, blocks_b_ff} * 12'd20;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;
endmodule

// ----- design/radio_tx_timeout_calc.sv -----
// Top level: packet airtime and transmit-hang timeout from a payload length.
// The pipeline has 27 register stages.
// Throughput: one transaction per cycle while rsp_ready is high; the 20-cell divider chain is fully pipelined.
// Stages advance independently, so bubbles collapse and a held response only
// stalls the stages behind it once they are full.
// Reset (synchronous, active high) empties the pipeline and restores settings.
module radio_tx_timeout_calc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [27:0] rsp_onair_us,
   output logic [15:0] rsp_timeout_ms,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   import rttc_pkg::*;

   logic                  mod_ff;
   logic [3:0]            sf_ff;
   logic [19:0]           bw_ff;
   logic [21:0]           br_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;
   div_type               chain [NUM_CELLS:0];

   logic [31:0] prod_in;
   logic [31:0] prod_d_ff;
   logic        mod_d_ff;
   logic [19:0] quot_d_ff;
   logic [30:0] lora_air;
   logic [27:0] air_in;
   logic [27:0] air_e_ff;
   logic        big_in;
   logic [27:0] round_air;
   logic [44:0] ms_prod_in;
   logic [27:0] air_f_ff;
   logic        big_f_ff;
   logic [44:0] ms_prod_ff;
   logic [16:0] ms_raw;
   logic [15:0] ms_in;
   logic [27:0] air_g_ff;
   logic [15:0] ms_g_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_LORA;
         sf_ff <= 4'd7;
         bw_ff <= 20'd125000;
         br_ff <= 22'd1300000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULATION: mod_ff <= csr_wdata[0];
            CSR_SPREADING: sf_ff <= csr_wdata[3:0];
            CSR_BANDWIDTH: bw_ff <= csr_wdata[19:0];
            CSR_BITRATE: br_ff <= csr_wdata;
            default: mod_ff <= mod_ff;
         endcase
      end
   end

   // Per-stage flow control: a stage loads when empty or when its successor loads.
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   rttc_prep u_prep (
      .clock             (clock),
      .en                (en[2:0]),
      .payload_length    (req_payload_length),
      .modulation        (mod_ff),
      .spreading_factor  (sf_ff),
      .lora_bandwidth_hz (bw_ff),
      .flrc_bitrate_bps  (br_ff),
      .cell_o            (chain[0])
   );

   // Divider chain: symbol time for LoRa, airtime for FLRC.
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      rttc_div_cell u_cell (
         .clock  (clock),
         .en     (en[g+3]),
         .cell_i (chain[g]),
         .cell_o (chain[g+1])
      );
   end

   // Quarter-symbol count times symbol time.
   assign prod_in = {12'd0, chain[NUM_CELLS].quot} * {20'd0, chain[NUM_CELLS].qsym};

   always_ff @(posedge clock) begin
      if (en[NUM_CELLS+3]) begin
         prod_d_ff <= prod_in;
         mod_d_ff <= chain[NUM_CELLS].modulation;
         quot_d_ff <= chain[NUM_CELLS].quot;
      end
   end

   // Round the quarter symbols up and saturate the airtime.
   always_comb begin
      lora_air = 31'(({1'b0, prod_d_ff} + 33'd3) >> 2);
      if (mod_d_ff == MOD_FLRC) begin
         air_in = {8'd0, quot_d_ff};
      end else if (lora_air > 31'd268435455) begin
         air_in = 28'd268435455;
      end else begin
         air_in = lora_air[27:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NUM_CELLS+4]) begin
         air_e_ff <= air_in;
      end
   end

   // Milliseconds rounded up: divide by 8, then by 125 through a reciprocal.
   always_comb begin
      big_in = air_e_ff > 28'd29975000;
      round_air = air_e_ff + 28'd999;
      ms_prod_in = round_air[24:3] * 23'd4294968;
   end

   always_ff @(posedge clock) begin
      if (en[NUM_CELLS+5]) begin
         air_f_ff <= air_e_ff;
         big_f_ff <= big_in;
         ms_prod_ff <= ms_prod_in;
      end
   end

   // Timeout is twice the milliseconds plus margin, clamped.
   always_comb begin
      ms_raw = {ms_prod_ff[44:29], 1'b0} + 17'd50;
      if (big_f_ff || ms_raw > 17'd60000) begin
         ms_in = 16'd60000;
      end else if (ms_raw < 17'd100) begin
         ms_in = 16'd100;
      end else begin
         ms_in = ms_raw[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NUM_CELLS+6]) begin
         air_g_ff <= air_f_ff;
         ms_g_ff <= ms_in;
      end
   end

   assign rsp_onair_us = air_g_ff;
   assign rsp_timeout_ms = ms_g_ff;
endmodule

// ----- design/rttc_checker.sv -----
// Port-level checks of the transmit timeout calculator, bound to the top level.
module rttc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_onair_us,
   input logic [15:0] rsp_timeout_ms
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A held response keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_timeout_ms)
         && $stable(rsp_onair_us))
      else $error("held response changed");

   // Timeout stays within its clamp range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_timeout_ms >= 16'd100 && rsp_timeout_ms <= 16'd60000)
      else $error("timeout out of range");

   // Short packets get the minimum timeout, long ones the maximum.
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_onair_us <= 28'd24000 |-> rsp_timeout_ms == 16'd100)
      else $error("short packet timeout not at minimum");

   a_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_onair_us > 28'd29975000 |-> rsp_timeout_ms == 16'd60000)
      else $error("long packet timeout not at maximum");

endmodule

bind radio_tx_timeout_calc rttc_checker u_rttc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_onair_us   (rsp_onair_us),
   .rsp_timeout_ms (rsp_timeout_ms)
);
